// ===== sv/dns_query_stream_parser_top_defines.svh =====
// ---------------------------------------------------------------------------
// DNS query stream parser assertion macros
// Shared concurrent check shorthands, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DNS_QUERY_STREAM_PARSER_TOP_DEFINES_SVH
`define DNS_QUERY_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication check.
`define DQSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define DQSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dqsp_pkg.sv =====
// ---------------------------------------------------------------------------
// DNS query stream parser package
// Item kind codes, flag field positions and the front-to-back bundle type.
// ---------------------------------------------------------------------------
`default_nettype none

package dqsp_pkg;

  // Result queue depth between parser and output stage.
  localparam int unsigned FIFO_DEPTH = 4;

  // Result item kinds.
  localparam logic [3:0] KIND_ID       = 4'd0;
  localparam logic [3:0] KIND_FLAGS    = 4'd1;
  localparam logic [3:0] KIND_QCOUNT   = 4'd2;
  localparam logic [3:0] KIND_CHAR     = 4'd3;
  localparam logic [3:0] KIND_NAME_END = 4'd4;
  localparam logic [3:0] KIND_QTYPE    = 4'd5;
  localparam logic [3:0] KIND_QCLASS   = 4'd6;
  localparam logic [3:0] KIND_ERROR    = 4'd7;
  localparam logic [3:0] KIND_PKT_END  = 4'd8;

  // Label separator character.
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Flags word layout.
  localparam int unsigned QR_BIT     = 15;
  localparam int unsigned OPCODE_HI  = 14;
  localparam int unsigned OPCODE_LO  = 11;
  localparam int unsigned AA_BIT     = 10;
  localparam int unsigned TC_BIT     = 9;
  localparam int unsigned RD_BIT     = 8;
  localparam int unsigned RA_BIT     = 7;
  localparam int unsigned RCODE_HI   = 3;

  // Everything one accepted byte produces: an optional main item and an
  // optional packet-end item that always comes second.
  typedef struct packed {
    logic        has_main;
    logic [3:0]  kind;
    logic [15:0] value;
    logic [15:0] qnum;
    logic        has_end;
    logic        end_ok;
  } bundle_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// ===== sv/dqsp_fifo.sv =====
// ---------------------------------------------------------------------------
// DNS query stream parser result queue
// Short register queue of result bundles between parser and output stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "dns_query_stream_parser_top_defines.svh"

module dqsp_fifo #(
  parameter int unsigned DEPTH = dqsp_pkg::FIFO_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire dqsp_pkg::bundle_t      push_data,
  input  wire logic                   pop,
  output dqsp_pkg::bundle_t           rd_data,
  output dqsp_pkg::fifo_status_t      status
);
  import dqsp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `DQSP_ASSERT_IMP(a_no_push_full, push, !status.full, "push into full result queue")
  `DQSP_ASSERT_IMP(a_no_pop_empty, pop, !status.empty, "pop from empty result queue")
  `DQSP_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count did not advance")

endmodule

`default_nettype wire

// ===== sv/dqsp_front.sv =====
// ---------------------------------------------------------------------------
// DNS query stream parser front end
// Accepts one packet byte per cycle while the result queue is not full, tracks
// the parse phase and builds the result bundle for that byte.
// ---------------------------------------------------------------------------
`default_nettype none

module dqsp_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_rx_byte,
  input  wire logic                   in_end_of_packet,
  input  wire dqsp_pkg::fifo_status_t q_status,
  output logic                        push,
  output dqsp_pkg::bundle_t           push_data
);
  import dqsp_pkg::*;

  typedef enum logic [7:0] {
    PH_HEADER    = 8'b0000_0001,
    PH_NAME_LEN  = 8'b0000_0010,
    PH_NAME_CHAR = 8'b0000_0100,
    PH_QTYPE_HI  = 8'b0000_1000,
    PH_QTYPE_LO  = 8'b0001_0000,
    PH_QCLASS_HI = 8'b0010_0000,
    PH_QCLASS_LO = 8'b0100_0000,
    PH_SKIP      = 8'b1000_0000
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [3:0]   hdr_off_r, hdr_off_nxt;
  logic [7:0]   held_r, held_nxt;
  logic [7:0]   left_r, left_nxt;
  logic         first_r, first_nxt;
  logic [15:0]  qexp_r, qexp_nxt;
  logic [15:0]  qdone_r, qdone_nxt;
  logic [16:0]  rsum_r, rsum_nxt;

  logic         accept;
  logic [15:0]  word;
  logic [15:0]  qdone_inc;
  logic [7:0]   left_dec;
  bundle_t      bnd;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign word      = {held_r, in_rx_byte};
  assign qdone_inc = qdone_r + 1'b1;
  assign left_dec  = left_r - 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_off_nxt = hdr_off_r;
    held_nxt    = held_r;
    left_nxt    = left_r;
    first_nxt   = first_r;
    qexp_nxt    = qexp_r;
    qdone_nxt   = qdone_r;
    rsum_nxt    = rsum_r;
    bnd         = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (!hdr_off_r[0]) begin
          held_nxt = in_rx_byte;
        end else begin
          unique case (hdr_off_r)
            4'd1: begin
              bnd.has_main = 1'b1;
              bnd.kind     = KIND_ID;
              bnd.value    = word;
            end
            4'd3: begin
              bnd.has_main = 1'b1;
              bnd.kind     = KIND_FLAGS;
              bnd.value    = word;
            end
            4'd5: begin
              qexp_nxt     = word;
              bnd.has_main = 1'b1;
              bnd.kind     = KIND_QCOUNT;
              bnd.value    = word;
            end
            4'd7: rsum_nxt = {1'b0, word};
            4'd9: rsum_nxt = rsum_r + {1'b0, word};
            default: begin
              // Last header byte: pick error, skip or question parsing.
              if (rsum_r != '0) begin
                bnd.has_main = 1'b1;
                bnd.kind     = KIND_ERROR;
                phase_nxt    = PH_SKIP;
              end else if (qexp_r == '0) begin
                phase_nxt    = PH_SKIP;
              end else begin
                phase_nxt    = PH_NAME_LEN;
                first_nxt    = 1'b1;
              end
            end
          endcase
        end
        if (hdr_off_r < 4'd11) begin
          hdr_off_nxt = hdr_off_r + 1'b1;
        end
      end
      PH_NAME_LEN: begin
        if (in_rx_byte == '0) begin
          bnd.has_main = 1'b1;
          bnd.kind     = KIND_NAME_END;
          bnd.qnum     = qdone_r;
          first_nxt    = 1'b1;
          phase_nxt    = PH_QTYPE_HI;
        end else begin
          if (!first_r) begin
            bnd.has_main = 1'b1;
            bnd.kind     = KIND_CHAR;
            bnd.value    = {8'd0, DOT_CHAR};
            bnd.qnum     = qdone_r;
          end
          first_nxt = 1'b0;
          left_nxt  = in_rx_byte;
          phase_nxt = PH_NAME_CHAR;
        end
      end
      PH_NAME_CHAR: begin
        bnd.has_main = 1'b1;
        bnd.kind     = KIND_CHAR;
        bnd.value    = {8'd0, in_rx_byte};
        bnd.qnum     = qdone_r;
        left_nxt     = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_NAME_LEN;
        end
      end
      PH_QTYPE_HI: begin
        held_nxt  = in_rx_byte;
        phase_nxt = PH_QTYPE_LO;
      end
      PH_QTYPE_LO: begin
        bnd.has_main = 1'b1;
        bnd.kind     = KIND_QTYPE;
        bnd.value    = word;
        bnd.qnum     = qdone_r;
        phase_nxt    = PH_QCLASS_HI;
      end
      PH_QCLASS_HI: begin
        held_nxt  = in_rx_byte;
        phase_nxt = PH_QCLASS_LO;
      end
      PH_QCLASS_LO: begin
        bnd.has_main = 1'b1;
        bnd.kind     = KIND_QCLASS;
        bnd.value    = word;
        bnd.qnum     = qdone_r;
        qdone_nxt    = qdone_inc;
        phase_nxt    = (qdone_inc == qexp_r) ? PH_SKIP : PH_NAME_LEN;
      end
      PH_SKIP: ;
      default: ;
    endcase

    // Packet end: report completeness, then drop all parse state.
    if (in_end_of_packet) begin
      bnd.has_end = 1'b1;
      bnd.end_ok  = (phase_nxt == PH_SKIP) && (rsum_nxt == '0);
      phase_nxt   = PH_HEADER;
      hdr_off_nxt = '0;
      held_nxt    = '0;
      left_nxt    = '0;
      first_nxt   = 1'b1;
      qexp_nxt    = '0;
      qdone_nxt   = '0;
      rsum_nxt    = '0;
    end
  end

  assign push      = accept && (bnd.has_main || bnd.has_end);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_off_r <= '0;
      held_r    <= '0;
      left_r    <= '0;
      first_r   <= 1'b1;
      qexp_r    <= '0;
      qdone_r   <= '0;
      rsum_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hdr_off_r <= hdr_off_nxt;
      held_r    <= held_nxt;
      left_r    <= left_nxt;
      first_r   <= first_nxt;
      qexp_r    <= qexp_nxt;
      qdone_r   <= qdone_nxt;
      rsum_r    <= rsum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dqsp_back.sv =====
// ---------------------------------------------------------------------------
// DNS query stream parser back end
// Unpacks queued bundles into single result items and holds them in the
// output register until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module dqsp_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dqsp_pkg::bundle_t      head,
  input  wire dqsp_pkg::fifo_status_t q_status,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [3:0]                  out_item_kind,
  output logic [15:0]                 out_item_value,
  output logic                        out_flag_qr,
  output logic [3:0]                  out_flag_opcode,
  output logic                        out_flag_aa,
  output logic                        out_flag_tc,
  output logic                        out_flag_rd,
  output logic                        out_flag_ra,
  output logic [3:0]                  out_flag_rcode,
  output logic [15:0]                 out_question_number
);
  import dqsp_pkg::*;

  logic         valid_r, valid_nxt;
  logic         sub_r, sub_nxt;
  logic [3:0]   kind_r;
  logic [15:0]  value_r;
  logic [15:0]  qnum_r;

  logic         load;
  logic         emit_main;
  logic         last;
  logic [3:0]   kind_sel;
  logic [15:0]  value_sel;
  logic [15:0]  qnum_sel;
  logic         is_flags;

  assign emit_main = !sub_r && head.has_main;
  assign last      = !(emit_main && head.has_end);
  assign load      = !q_status.empty && (!valid_r || !out_stall);
  assign pop       = load && last;

  always_comb begin
    if (emit_main) begin
      kind_sel  = head.kind;
      value_sel = head.value;
      qnum_sel  = head.qnum;
    end else begin
      kind_sel  = KIND_PKT_END;
      value_sel = {15'd0, head.end_ok};
      qnum_sel  = '0;
    end
  end

  always_comb begin
    sub_nxt   = load ? !last : sub_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_sel;
      value_r <= value_sel;
      qnum_r  <= qnum_sel;
    end
  end

  // Flag fields read as zero on every item but the flags item.
  assign is_flags            = (kind_r == KIND_FLAGS);
  assign out_valid           = valid_r;
  assign out_item_kind       = kind_r;
  assign out_item_value      = value_r;
  assign out_question_number = qnum_r;
  assign out_flag_qr         = is_flags & value_r[QR_BIT];
  assign out_flag_opcode     = is_flags ? value_r[OPCODE_HI:OPCODE_LO] : 4'd0;
  assign out_flag_aa         = is_flags & value_r[AA_BIT];
  assign out_flag_tc         = is_flags & value_r[TC_BIT];
  assign out_flag_rd         = is_flags & value_r[RD_BIT];
  assign out_flag_ra         = is_flags & value_r[RA_BIT];
  assign out_flag_rcode      = is_flags ? value_r[RCODE_HI:0] : 4'd0;

endmodule

`default_nettype wire

// ===== sv/dns_query_stream_parser_top.sv =====
// ---------------------------------------------------------------------------
// DNS query stream parser
// Parses a DNS query packet byte by byte into header, name, type and class
// result items, with a packet-end item carrying a completeness bit.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  rx_byte[8], end_of_packet[1]
//   out_     output     out_valid/out_stall item kind/value, flags, question no.
//
// One byte is accepted per cycle while the result queue has room; the parser
// state updates in that same cycle, so back-to-back bytes need no gaps.
// A result item goes into the result queue, then into the output register.
// The output stage moves one item per cycle while out_stall is low; a byte that
// ends a packet and also produces an item yields two items, which the result
// queue absorbs.
// Reset (rst_n low, synchronous) returns the parser to the header phase and
// empties the queue and output register.
// out_stall backs up into the queue; in_stall rises only when the queue is full.
//
`default_nettype none

module dns_query_stream_parser_top #(
  parameter int unsigned FIFO_DEPTH = dqsp_pkg::FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_end_of_packet,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_item_kind,
  output logic [15:0]      out_item_value,
  output logic             out_flag_qr,
  output logic [3:0]       out_flag_opcode,
  output logic             out_flag_aa,
  output logic             out_flag_tc,
  output logic             out_flag_rd,
  output logic             out_flag_ra,
  output logic [3:0]       out_flag_rcode,
  output logic [15:0]      out_question_number
);
  import dqsp_pkg::*;

  // Front to queue: one bundle per transaction that produces anything.
  logic          push;
  bundle_t       push_data;
  // Queue to back: head bundle and pop.
  logic          pop;
  bundle_t       head;
  fifo_status_t  q_status;

  // Parse each accepted byte and classify what it produces.
  dqsp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_packet (in_end_of_packet),
    .q_status         (q_status),
    .push             (push),
    .push_data        (push_data)
  );

  // Decouple parsing from output back-pressure.
  dqsp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (head),
    .status    (q_status)
  );

  // Emit queued items one transaction at a time.
  dqsp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .q_status            (q_status),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_item_kind       (out_item_kind),
    .out_item_value      (out_item_value),
    .out_flag_qr         (out_flag_qr),
    .out_flag_opcode     (out_flag_opcode),
    .out_flag_aa         (out_flag_aa),
    .out_flag_tc         (out_flag_tc),
    .out_flag_rd         (out_flag_rd),
    .out_flag_ra         (out_flag_ra),
    .out_flag_rcode      (out_flag_rcode),
    .out_question_number (out_question_number)
  );

endmodule

`default_nettype wire

// ===== test/dns_query_stream_parser_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS query stream parser checker
// Watches both channels of the parser. Each accepted byte runs through a
// local copy of the parsing rules. The items it produces are queued, and
// every item the parser emits is compared with the oldest one, field by field.
// ---------------------------------------------------------------------------
module dns_query_stream_parser_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_end_of_packet,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_item_kind,
  input  wire logic [15:0] out_item_value,
  input  wire logic        out_flag_qr,
  input  wire logic [3:0]  out_flag_opcode,
  input  wire logic        out_flag_aa,
  input  wire logic        out_flag_tc,
  input  wire logic        out_flag_rd,
  input  wire logic        out_flag_ra,
  input  wire logic [3:0]  out_flag_rcode,
  input  wire logic [15:0] out_question_number,
  output int               mismatch_count,
  output int               items_pending
);
  import dqsp_pkg::*;

  typedef enum logic [2:0] {
    SEC_HEADER, SEC_LABEL_LEN, SEC_LABEL_CHAR, SEC_QTYPE_HI,
    SEC_QTYPE_LO, SEC_QCLASS_HI, SEC_QCLASS_LO, SEC_DISCARD
  } section_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic        qr;
    logic [3:0]  opcode;
    logic        aa;
    logic        tc;
    logic        rd;
    logic        ra;
    logic [3:0]  rcode;
    logic [15:0] qnum;
  } dns_item_t;

  dns_item_t   dns_items_due[$];
  section_e    section;
  logic [3:0]  header_pos;
  logic [7:0]  high_byte;
  logic [7:0]  label_left;
  logic        first_label;
  logic [15:0] questions_total;
  logic [15:0] questions_seen;
  logic [16:0] record_sum;
  int          items_checked;

  initial begin
    mismatch_count = 0;
    items_pending  = 0;
    items_checked  = 0;
  end

  function automatic void clear_parser();
    section         = SEC_HEADER;
    header_pos      = '0;
    high_byte       = '0;
    label_left      = '0;
    first_label     = 1'b1;
    questions_total = '0;
    questions_seen  = '0;
    record_sum      = '0;
  endfunction

  function automatic void queue_item(input logic [3:0] kind, input logic [15:0] value,
                                     input logic [15:0] qnum);
    dns_item_t it;
    it       = '0;
    it.kind  = kind;
    it.value = value;
    it.qnum  = qnum;
    dns_items_due.push_back(it);
  endfunction

  // Apply one received byte to the parse state and queue what it yields.
  function automatic void parse_rx_byte(input logic [7:0] b, input logic eop);
    logic [15:0] word;
    logic [15:0] qn;
    dns_item_t   fl;
    word = {high_byte, b};
    qn   = questions_seen;
    case (section)
      SEC_HEADER: begin
        if (!header_pos[0]) begin
          high_byte = b;
        end else if (header_pos == 4'd1) begin
          queue_item(KIND_ID, word, '0);
        end else if (header_pos == 4'd3) begin
          fl        = '0;
          fl.kind   = KIND_FLAGS;
          fl.value  = word;
          fl.qr     = word[QR_BIT];
          fl.opcode = word[OPCODE_HI:OPCODE_LO];
          fl.aa     = word[AA_BIT];
          fl.tc     = word[TC_BIT];
          fl.rd     = word[RD_BIT];
          fl.ra     = word[RA_BIT];
          fl.rcode  = word[RCODE_HI:0];
          dns_items_due.push_back(fl);
        end else if (header_pos == 4'd5) begin
          questions_total = word;
          queue_item(KIND_QCOUNT, word, '0);
        end else if (header_pos == 4'd7) begin
          record_sum = {1'b0, word};
        end else if (header_pos == 4'd9) begin
          record_sum = record_sum + {1'b0, word};
        end else if (record_sum != '0) begin
          queue_item(KIND_ERROR, '0, '0);
          section = SEC_DISCARD;
        end else if (questions_total == '0) begin
          section = SEC_DISCARD;
        end else begin
          section     = SEC_LABEL_LEN;
          first_label = 1'b1;
        end
        if (header_pos < 4'd11) header_pos = header_pos + 4'd1;
      end
      SEC_LABEL_LEN: begin
        if (b == 8'h00) begin
          queue_item(KIND_NAME_END, '0, qn);
          first_label = 1'b1;
          section     = SEC_QTYPE_HI;
        end else begin
          if (!first_label) queue_item(KIND_CHAR, {8'h00, DOT_CHAR}, qn);
          first_label = 1'b0;
          label_left  = b;
          section     = SEC_LABEL_CHAR;
        end
      end
      SEC_LABEL_CHAR: begin
        queue_item(KIND_CHAR, {8'h00, b}, qn);
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) section = SEC_LABEL_LEN;
      end
      SEC_QTYPE_HI: begin
        high_byte = b;
        section   = SEC_QTYPE_LO;
      end
      SEC_QTYPE_LO: begin
        queue_item(KIND_QTYPE, word, qn);
        section = SEC_QCLASS_HI;
      end
      SEC_QCLASS_HI: begin
        high_byte = b;
        section   = SEC_QCLASS_LO;
      end
      SEC_QCLASS_LO: begin
        queue_item(KIND_QCLASS, word, qn);
        questions_seen = questions_seen + 16'd1;
        section = (questions_seen == questions_total) ? SEC_DISCARD : SEC_LABEL_LEN;
      end
      default: ;
    endcase
    if (eop) begin
      queue_item(KIND_PKT_END, {15'd0, (section == SEC_DISCARD) && (record_sum == '0)}, '0);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("item %0d %s: got 0x%0h, expected 0x%0h",
                                items_checked, field, got, want));
  endtask

  task automatic compare_item();
    dns_item_t want;
    if (dns_items_due.size() == 0) begin
      report_mismatch($sformatf("item kind %0d value 0x%0h arrived with none expected",
                                out_item_kind, out_item_value));
      return;
    end
    want = dns_items_due.pop_front();
    check_field("kind", 16'(out_item_kind), 16'(want.kind));
    check_field("value", out_item_value, want.value);
    check_field("qr", 16'(out_flag_qr), 16'(want.qr));
    check_field("opcode", 16'(out_flag_opcode), 16'(want.opcode));
    check_field("aa", 16'(out_flag_aa), 16'(want.aa));
    check_field("tc", 16'(out_flag_tc), 16'(want.tc));
    check_field("rd", 16'(out_flag_rd), 16'(want.rd));
    check_field("ra", 16'(out_flag_ra), 16'(want.ra));
    check_field("rcode", 16'(out_flag_rcode), 16'(want.rcode));
    check_field("question number", out_question_number, want.qnum);
    items_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      dns_items_due.delete();
    end else begin
      if (out_valid && !out_stall) compare_item();
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte, in_end_of_packet);
    end
    items_pending = dns_items_due.size();
  end

endmodule

// ===== test/dns_query_stream_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS query stream parser testbench
// Feeds byte streams of DNS query packets into the parser: a handful of
// hand-built packets for the corner cases, then random well-formed, broken
// and noise packets under varying idle and stall rates. A checker beside
// the parser predicts and compares every item; this module gives the verdict.
// ---------------------------------------------------------------------------
module dns_query_stream_parser_top_tb;

  localparam int          CLK_PERIOD  = 4;
  localparam int          RESET_LEN   = 8;
  localparam int unsigned RAND_BYTES  = 850;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          LONG_HOLD   = 300;
  localparam int          DRAIN_WAIT  = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_item_kind;
  logic [15:0] out_item_value;
  logic        out_flag_qr;
  logic [3:0]  out_flag_opcode;
  logic        out_flag_aa;
  logic        out_flag_tc;
  logic        out_flag_rd;
  logic        out_flag_ra;
  logic [3:0]  out_flag_rcode;
  logic [15:0] out_question_number;

  int          mismatch_count;
  int          items_pending;

  // Idle and stall rates in percent, changed by the stimulus as it runs.
  int          send_idle_pct = 17;
  int          recv_stall_pct = 55;
  // Long receiver hold-offs requested by the stimulus and served by the receiver.
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  logic [7:0]  pkt_bytes[$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  dns_query_stream_parser_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .in_end_of_packet    (in_end_of_packet),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_item_kind       (out_item_kind),
    .out_item_value      (out_item_value),
    .out_flag_qr         (out_flag_qr),
    .out_flag_opcode     (out_flag_opcode),
    .out_flag_aa         (out_flag_aa),
    .out_flag_tc         (out_flag_tc),
    .out_flag_rd         (out_flag_rd),
    .out_flag_ra         (out_flag_ra),
    .out_flag_rcode      (out_flag_rcode),
    .out_question_number (out_question_number)
  );

  dns_query_stream_parser_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .in_end_of_packet    (in_end_of_packet),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_item_kind       (out_item_kind),
    .out_item_value      (out_item_value),
    .out_flag_qr         (out_flag_qr),
    .out_flag_opcode     (out_flag_opcode),
    .out_flag_aa         (out_flag_aa),
    .out_flag_tc         (out_flag_tc),
    .out_flag_rd         (out_flag_rd),
    .out_flag_ra         (out_flag_ra),
    .out_flag_rcode      (out_flag_rcode),
    .out_question_number (out_question_number),
    .mismatch_count      (mismatch_count),
    .items_pending       (items_pending)
  );

  // Receiver: stall at random, or hold off for a long stretch on request so
  // the result queue fills up and the parser has to stall its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served < hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run once the cycle count passes the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one byte: idle at random first, then hold the transaction until the
  // parser takes it. Valid never looks at stall.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_rx_byte       <= b;
    in_end_of_packet <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the assembled packet, marking its last byte, and drop it.
  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  function automatic void add_word(input logic [15:0] w);
    pkt_bytes.push_back(w[15:8]);
    pkt_bytes.push_back(w[7:0]);
  endfunction

  function automatic void add_header(input logic [15:0] id, input logic [15:0] flags,
                                     input logic [15:0] qd, input logic [15:0] an,
                                     input logic [15:0] ns, input logic [15:0] ar);
    add_word(id);
    add_word(flags);
    add_word(qd);
    add_word(an);
    add_word(ns);
    add_word(ar);
  endfunction

  // Append one question: a name of random labels with random bytes, then
  // random type and class.
  function automatic void add_question(input int unsigned max_labels,
                                       input int unsigned max_len);
    int unsigned labels;
    int unsigned len;
    labels = $urandom_range(max_labels);
    for (int i = 0; i < labels; i++) begin
      len = $urandom_range(max_len, 1);
      pkt_bytes.push_back(8'(len));
      repeat (len) pkt_bytes.push_back(8'($urandom_range(255)));
    end
    pkt_bytes.push_back(8'h00);
    add_word(16'($urandom));
    add_word(16'($urandom));
  endfunction

  initial begin
    int unsigned rand_start;
    int unsigned done_bytes;
    int unsigned pick;
    int unsigned qd;
    int unsigned given;
    int unsigned cut;
    bit          pressure_sent;

    pressure_sent = 1'b0;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two questions with extreme header words; the second name is empty and
    // its class byte ends the packet, so two items leave on one byte.
    add_header(16'hFFFF, 16'hFFFF, 16'd2, 16'd0, 16'd0, 16'hFFFF);
    pkt_bytes.push_back(8'd1);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'd1);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(8'h00);
    add_word(16'hFFFF);
    add_word(16'h0000);
    pkt_bytes.push_back(8'h00);
    add_word(16'h0000);
    add_word(16'hFFFF);
    send_packet();

    // Nonzero answer count: error on the last header byte, which also ends it.
    add_header(16'h0000, 16'h0000, 16'd1, 16'hFFFF, 16'd0, 16'd0);
    send_packet();

    // Answer plus authority counts wrap to a 17-bit carry; trailing bytes dropped.
    add_header(16'h8001, 16'h0080, 16'd3, 16'hFFFF, 16'd1, 16'd0);
    add_word(16'hA5A5);
    send_packet();

    // Zero questions: everything after the header is ignored, packet complete.
    add_header(16'h1234, 16'h7800, 16'd0, 16'd0, 16'd0, 16'd7);
    add_word(16'h5A5A);
    pkt_bytes.push_back(8'h03);
    send_packet();

    // Length byte with its top bits set counts as a plain 192-byte label.
    add_header(16'h4321, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
    pkt_bytes.push_back(8'hC0);
    repeat (192) pkt_bytes.push_back(8'($urandom_range(255)));
    pkt_bytes.push_back(8'h00);
    add_word(16'd1);
    add_word(16'd1);
    send_packet();

    // Early ends: a single byte, mid header, mid name.
    pkt_bytes.push_back(8'h77);
    send_packet();
    add_word(16'hBEEF);
    pkt_bytes.push_back(8'h81);
    send_packet();
    add_header(16'h0F0F, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    pkt_bytes.push_back(8'd4);
    pkt_bytes.push_back(8'h61);
    send_packet();

    // Random part: three idle regimes, each about a third of the bytes.
    rand_start = bytes_sent;
    done_bytes = 0;
    while (done_bytes < RAND_BYTES) begin
      if (done_bytes >= 2 * RAND_BYTES / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Hold the receiver off once while the sender keeps offering.
        if (!pressure_sent) begin
          hold_requests  = hold_requests + 1;
          pressure_sent = 1'b1;
        end
      end else if (done_bytes >= RAND_BYTES / 3) begin
        send_idle_pct  = 55;
        recv_stall_pct = 17;
      end

      pick = $urandom_range(99);
      if (pick < 65) begin
        // Well-formed query, occasionally with zero questions or a long label.
        qd = ($urandom_range(19) == 0) ? 0 : $urandom_range(3, 1);
        add_header(16'($urandom), 16'($urandom), 16'(qd), 16'd0, 16'd0, 16'($urandom));
        repeat (qd) add_question(3, ($urandom_range(49) == 0) ? 255 : 5);
        repeat ($urandom_range(2)) pkt_bytes.push_back(8'($urandom_range(255)));
      end else if (pick < 75) begin
        // Question count above what the packet carries: ends incomplete.
        given = $urandom_range(2);
        qd = $urandom_range(65535, given + 1);
        add_header(16'($urandom), 16'($urandom), 16'(qd), 16'd0, 16'd0, 16'($urandom));
        repeat (given) add_question(2, 4);
      end else if (pick < 85) begin
        // Nonzero answer or authority count, then a few stray bytes.
        add_header(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(1)), 16'($urandom));
        repeat ($urandom_range(3)) pkt_bytes.push_back(8'($urandom_range(255)));
      end else if (pick < 94) begin
        // Well-formed query cut short at a random byte.
        qd = $urandom_range(2, 1);
        add_header(16'($urandom), 16'($urandom), 16'(qd), 16'd0, 16'd0, 16'd0);
        repeat (qd) add_question(3, 5);
        cut = $urandom_range(pkt_bytes.size() - 1, 1);
        pkt_bytes = pkt_bytes[0:cut - 1];
      end else begin
        // Pure noise.
        repeat ($urandom_range(16, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
      end
      send_packet();
      done_bytes = bytes_sent - rand_start;
    end

    // Drop valid, let the last expectations register, then drain.
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (items_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
